// File: sv/assert_macros.svh
// Assertion macros used by the controller of the 2x2 downsampler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// ante holds at an edge -> cons holds at the same edge
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// ante holds at an edge -> cons holds at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/rgbd_ds_pkg.sv
// Package: types, constants and state codes of the 2x2 RGB-D downsampler
package rgbd_ds_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_INV_SHIFT = 30;

    localparam int CFG_W_BITS   = 11;
    localparam int CFG_H_BITS   = 12;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 12;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_W_BITS-1:0] CFG_W_RESET = 11'd640;
    localparam logic [CFG_H_BITS-1:0] CFG_H_RESET = 12'd480;

    typedef struct packed {
        logic [15:0] gray_in;
        logic [15:0] depth_in;
    } t_pix_in;

    typedef struct packed {
        logic [15:0] gray_avg;
        logic [15:0] depth_avg;
        logic        frame_end;
    } t_blk_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INV,
        S_INV_WAIT,
        S_PAIR,
        S_MEAN,
        S_MEAN_WAIT,
        S_OUT
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic capture;    // take the input transaction
        logic div_inv;    // start inverse-depth division
        logic div_mean;   // start harmonic-mean division
        logic pair_step;  // combine pixel pair, update hold / line buffer
        logic advance;    // step column / row
        logic load_out;   // load the output register
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic depth_zero;
        logic div_done;
        logic col_odd;
        logic row_odd;
        logic mean_needed;
        logic out_free;
    } t_dp_stat;

endpackage

// File: sv/rgbd_ds_ram.sv
// Generic single-port-write, registered-read RAM
module rgbd_ds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/rgbd_ds_div.sv
// Radix-2 restoring divider, one quotient bit per cycle
module rgbd_ds_div #(
    parameter int N = 33
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [N-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quotient
);
    localparam int CNTW = $clog2(N + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [N-1:0]    r_rem, n_rem;
    logic [N-1:0]    r_dvd, n_dvd;
    logic [N-1:0]    r_dvs, n_dvs;
    logic [N-1:0]    r_quo, n_quo;
    logic [N:0]      w_trial;
    logic            w_ge;

    // One step: shift in next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dvd[N-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem = w_ge ? N'(w_trial - {1'b0, r_dvs}) : N'(w_trial);
            n_dvd = {r_dvd[N-2:0], 1'b0};
            n_quo = {r_quo[N-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNTW'(N - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: sv/rgbd_ds_dp.sv
// Datapath: config registers, positions, pair sums, line buffer, divider, output register
module rgbd_ds_dp
    import rgbd_ds_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int INV_SHIFT = DEF_INV_SHIFT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  t_pix_in                  i_in_data,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output t_blk_out                 o_out_data
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int AW    = CW - 1;
    localparam int SLOTS = MAX_WIDTH / 2;
    localparam int CMPW  = (CW + 1 > CFG_W_BITS + 1) ? CW + 1 : CFG_W_BITS + 1;
    localparam int IW    = INV_SHIFT + 1;   // one inverse depth
    localparam int PW    = INV_SHIFT + 2;   // pair of inverse depths
    localparam int N     = INV_SHIFT + 3;   // block sum, divider width
    localparam int RW    = 17 + PW + 2;     // line buffer word

    logic [CFG_W_BITS-1:0] r_cfg_w;
    logic [CFG_H_BITS-1:0] r_cfg_h;
    logic [CW-1:0]         r_col;
    logic [CFG_H_BITS-1:0] r_row;
    logic [15:0]           r_gray;
    logic [15:0]           r_depth;
    logic [15:0]           r_hold_gray;
    logic [IW-1:0]         r_hold_inv;
    logic                  r_hold_vld;
    logic [17:0]           r_gs;
    logic [N-1:0]          r_is;
    logic [2:0]            r_cnt;
    logic                  r_out_valid;
    t_blk_out              r_out;

    logic [CMPW-1:0]       w_eff_w;
    logic [CFG_H_BITS-1:0] w_eff_h;
    logic [CMPW-1:0]       w_col_ext;
    logic                  w_row_wrap;
    logic                  w_col_wrap;
    logic                  w_last_blk;
    logic [IW-1:0]         w_inv;
    logic                  w_vld;
    logic [16:0]           w_pg;
    logic [PW-1:0]         w_pi;
    logic [1:0]            w_pc;
    logic [RW-1:0]         w_rd;
    logic [N-1:0]          w_dividend;
    logic [N-1:0]          w_divisor;
    logic                  w_div_done;
    logic [N-1:0]          w_quo;
    logic [15:0]           w_davg;
    logic [17:0]           w_gsum_rnd;

    // Effective frame size with clamping
    always_comb begin
        if (CMPW'(r_cfg_w) > CMPW'(MAX_WIDTH)) begin
            w_eff_w = CMPW'(MAX_WIDTH);
        end else if (r_cfg_w < CFG_W_BITS'(2)) begin
            w_eff_w = CMPW'(2);
        end else begin
            w_eff_w = CMPW'(r_cfg_w);
        end
        w_eff_h = (r_cfg_h < CFG_H_BITS'(2)) ? CFG_H_BITS'(2) : r_cfg_h;
    end

    assign w_col_ext  = CMPW'(r_col);
    assign w_col_wrap = (w_col_ext + 1'b1) >= w_eff_w;
    assign w_row_wrap = ({1'b0, r_row} + 1'b1) >= {1'b0, w_eff_h};
    assign w_last_blk = (r_row == {w_eff_h[CFG_H_BITS-1:1], 1'b0} - 1'b1) &&
                        (w_col_ext == {w_eff_w[CMPW-1:1], 1'b0} - 1'b1);

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W_RESET;
            r_cfg_h <= CFG_H_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_BITS-1:0];
                CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_data;
                default:        r_cfg_h <= r_cfg_h;
            endcase
        end
    end

    // Position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.advance) begin
            if (w_col_wrap) begin
                r_col <= '0;
                r_row <= w_row_wrap ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_gray  <= i_in_data.gray_in;
            r_depth <= i_in_data.depth_in;
        end
    end

    // Shared divider: inverse depth or harmonic mean
    assign w_dividend = i_cmd.div_mean ? (N'(r_cnt) << INV_SHIFT) : (N'(1) << INV_SHIFT);
    assign w_divisor  = i_cmd.div_mean ? r_is : N'(r_depth);

    rgbd_ds_div #(
        .N (N)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_inv | i_cmd.div_mean),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_vld = (r_depth != 16'd0);
    assign w_inv = w_vld ? w_quo[IW-1:0] : '0;

    // Pair sums
    assign w_pg = {1'b0, r_hold_gray} + {1'b0, r_gray};
    assign w_pi = {1'b0, r_hold_inv} + {1'b0, w_inv};
    assign w_pc = {1'b0, r_hold_vld} + {1'b0, w_vld};

    // Line buffer of upper-row pair sums
    rgbd_ds_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pair_step & r_col[0] & ~r_row[0]),
        .i_waddr (r_col[CW-1:1]),
        .i_wdata ({w_pg, w_pi, w_pc}),
        .i_raddr (r_col[AW:1]),
        .o_rdata (w_rd)
    );

    // Left pixel hold and block totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_gray <= '0;
            r_hold_inv  <= '0;
            r_hold_vld  <= 1'b0;
        end else if (i_cmd.pair_step && !r_col[0]) begin
            r_hold_gray <= r_gray;
            r_hold_inv  <= w_inv;
            r_hold_vld  <= w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_step) begin
            r_gs  <= {1'b0, w_pg} + {1'b0, w_rd[RW-1 -: 17]};
            r_is  <= {1'b0, w_pi} + {1'b0, w_rd[PW+1:2]};
            r_cnt <= {1'b0, w_pc} + {1'b0, w_rd[1:0]};
        end
    end

    // Result values
    assign w_gsum_rnd = r_gs + 18'd2;
    always_comb begin
        if (!o_stat.mean_needed) begin
            w_davg = 16'd0;
        end else if (|w_quo[N-1:16]) begin
            w_davg = 16'hFFFF;
        end else begin
            w_davg = w_quo[15:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.gray_avg  <= w_gsum_rnd[17:2];
            r_out.depth_avg <= w_davg;
            r_out.frame_end <= w_last_blk;
        end
    end

    assign o_stat.depth_zero  = ~w_vld;
    assign o_stat.div_done    = w_div_done;
    assign o_stat.col_odd     = r_col[0];
    assign o_stat.row_odd     = r_row[0];
    assign o_stat.mean_needed = (r_cnt != 3'd0) && (r_is != '0);
    assign o_stat.out_free    = ~r_out_valid | ~i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// File: sv/rgbd_ds_ctrl.sv
// Controller: sequences capture, divisions, pair update and result load
`include "assert_macros.svh"
module rgbd_ds_ctrl
    import rgbd_ds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_INV;
            S_INV:       n_state = i_stat.depth_zero ? S_PAIR : S_INV_WAIT;
            S_INV_WAIT:  if (i_stat.div_done) n_state = S_PAIR;
            S_PAIR:      n_state = (i_stat.col_odd && i_stat.row_odd) ? S_MEAN : S_IDLE;
            S_MEAN:      n_state = i_stat.mean_needed ? S_MEAN_WAIT : S_OUT;
            S_MEAN_WAIT: if (i_stat.div_done) n_state = S_OUT;
            S_OUT:       if (i_stat.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: o_cmd.capture = w_accept;
            S_INV:  o_cmd.div_inv = ~i_stat.depth_zero;
            S_PAIR: begin
                o_cmd.pair_step = 1'b1;
                o_cmd.advance   = ~(i_stat.col_odd & i_stat.row_odd);
            end
            S_MEAN: o_cmd.div_mean = i_stat.mean_needed;
            S_OUT: begin
                o_cmd.load_out = i_stat.out_free;
                o_cmd.advance  = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_IMPL(a_done_in_wait, i_clk, i_rst_n, i_stat.div_done, (r_state == S_INV_WAIT) || (r_state == S_MEAN_WAIT), "divider finished outside a wait state")
    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n, o_cmd.load_out, i_stat.out_free, "result loaded over a held result")
    `ASSERT_NEXT(a_accept_inv, i_clk, i_rst_n, w_accept, r_state == S_INV, "accepted transaction not processed")
endmodule

// File: sv/rgbd_frame_downsample_2x2_core.sv
// Top level of the 2x2 RGB-D frame downsampler
//
//  channel  direction  handshake                    payload
//  cfg      in         i_cfg_we                     i_cfg_idx, i_cfg_data
//  pixel    in         i_in_valid / o_in_stall      i_in_data  (t_pix_in)
//  block    out        o_out_valid / i_out_stall    o_out_data (t_blk_out)
//
// One pixel at a time. A pixel is captured, divided into an inverse depth when
// its depth is nonzero, and combined in the pair step; a block's bottom-right
// pixel adds a mean division when any depth is valid, then the output load.
// Both divisions use the one shared bit-serial divider.
// Reset is synchronous, active low; the line buffer needs no clearing.
// A held result stalls only the final step of the next bottom-right pixel.
module rgbd_frame_downsample_2x2_core
    import rgbd_ds_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int INV_SHIFT = DEF_INV_SHIFT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_pix_in                  i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_blk_out                 o_out_data
);
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rgbd_ds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rgbd_ds_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .INV_SHIFT (INV_SHIFT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );
endmodule

// File: tb/sv/rgbd_ds_checker.sv
// Checker for the 2x2 RGB-D downsampler: predicts each block and compares it with the output
`timescale 1ns / 1ps

module rgbd_ds_checker
    import rgbd_ds_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int INV_SHIFT = DEF_INV_SHIFT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  t_pix_in                  i_in_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  t_blk_out                 i_out_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int SLOTS = MAX_WIDTH / 2;

    // Shadow configuration and line-buffer state
    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    logic [16:0]           upper_gray [SLOTS];
    logic [63:0]           upper_inv  [SLOTS];
    logic [1:0]            upper_cnt  [SLOTS];
    logic [16:0]           left_gray;
    logic [63:0]           left_inv;
    logic [1:0]            left_cnt;
    int unsigned           col_pos;
    int unsigned           row_pos;
    t_blk_out              block_queue [$];
    int                    fails;

    assign o_fail_count = fails;
    assign o_pending    = block_queue.size();

    // Advance the shadow state by one pixel; queue the block it completes
    task automatic absorb_pixel(input t_pix_in px);
        int unsigned w, h, slot;
        logic [63:0] inv, pi, isum, davg;
        logic [1:0]  valid;
        logic [16:0] pg;
        logic [18:0] gsum;
        logic [2:0]  cnt;
        t_blk_out    blk;
        w = (width_reg < 2) ? 2 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg < 2) ? 2 : height_reg;
        inv = 0;
        valid = 0;
        if (px.depth_in != 0) begin
            inv = (64'd1 << INV_SHIFT) / px.depth_in;
            valid = 1;
        end
        if (col_pos[0] == 1'b0) begin
            left_gray = px.gray_in;
            left_inv = inv;
            left_cnt = valid;
        end else begin
            slot = (col_pos >> 1) % SLOTS;
            pg = left_gray + px.gray_in;
            pi = left_inv + inv;
            if (row_pos[0] == 1'b0) begin
                upper_gray[slot] = pg;
                upper_inv[slot] = pi;
                upper_cnt[slot] = left_cnt + valid;
            end else begin
                gsum = pg + upper_gray[slot];
                isum = pi + upper_inv[slot];
                cnt = left_cnt + valid + upper_cnt[slot];
                davg = 0;
                if (cnt != 0 && isum != 0) begin
                    davg = (64'(cnt) << INV_SHIFT) / isum;
                    if (davg > 65535) davg = 65535;
                end
                blk.gray_avg = 16'((gsum + 2) >> 2);
                blk.depth_avg = davg[15:0];
                blk.frame_end = (row_pos == ((h >> 1) << 1) - 1) &&
                                (col_pos == ((w >> 1) << 1) - 1);
                block_queue = {block_queue, blk};
            end
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    // Compare one output transaction with the oldest prediction
    task automatic check_block(input t_blk_out got);
        t_blk_out want;
        if (block_queue.size() == 0) begin
            $error("unexpected block: gray_avg %0d depth_avg %0d frame_end %0d",
                   got.gray_avg, got.depth_avg, got.frame_end);
            fails++;
        end else begin
            want = block_queue.pop_front();
            if (got.gray_avg !== want.gray_avg) begin
                $error("gray_avg expected %0d actual %0d", want.gray_avg, got.gray_avg);
                fails++;
            end
            if (got.depth_avg !== want.depth_avg) begin
                $error("depth_avg expected %0d actual %0d", want.depth_avg, got.depth_avg);
                fails++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end expected %0d actual %0d", want.frame_end, got.frame_end);
                fails++;
            end
        end
    endtask

    initial fails = 0;

    // Watch all three channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg <= CFG_W_RESET;
            height_reg <= CFG_H_RESET;
            left_gray <= '0;
            left_inv <= '0;
            left_cnt <= '0;
            col_pos <= 0;
            row_pos <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_WIDTH) width_reg = i_cfg_data[CFG_W_BITS-1:0];
                else if (i_cfg_idx == CFG_IDX_HEIGHT) height_reg = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) check_block(i_out_data);
            if (i_in_valid && !i_in_stall) absorb_pixel(i_in_data);
        end
    end

endmodule

// File: tb/sv/tb.sv
// Testbench top: drives frames and configuration into the downsampler and gives the verdict
`timescale 1ns / 1ps

module tb;
    import rgbd_ds_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    t_pix_in                  i_in_data;
    logic                     o_out_valid;
    logic                     i_out_stall;
    t_blk_out                 o_out_data;
    int                       fail_count;
    int                       pending;
    bit                       quiet;
    int                       idle_cycles;
    int                       random_pixels;

    rgbd_frame_downsample_2x2_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    rgbd_ds_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: random stall before each output transaction
    initial begin
        int n;
        i_out_stall <= 1'b0;
        forever begin
            n = quiet ? 0 : $urandom_range(0, 18);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL rgbd_frame_downsample_2x2_core");
            $finish;
        end
    end

    // One pixel transaction after a random gap; valid stays high when the gap is zero
    task automatic send_pixel(input logic [15:0] gray, input logic [15:0] depth);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{gray_in: gray, depth_in: depth};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Register write once the block has drained
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_depth(input int sparse);
        int r;
        r = $urandom_range(0, 7);
        if (sparse != 0) return (r < 6) ? 16'd0 : 16'($urandom);
        case (r)
            0, 1: return 16'd0;
            2: return 16'd1;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(1, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    // Directed content: one pattern per 2x2 block of a 4x4 frame
    task automatic directed_pixel(input int col, input int row);
        case ((row / 2) * 2 + col / 2)
            0: send_pixel(16'hFFFF, 16'hFFFF);
            1: send_pixel(16'h0000, 16'h0000);
            2: send_pixel(16'(1 + (col & 1)), ((col + row) & 1) ? 16'd1 : 16'd0);
            default: send_pixel(16'($urandom), 16'($urandom_range(1, 16)));
        endcase
    endtask

    // Full frame with the given register values; mode 0 random, 1 sparse depth, 2 directed
    task automatic run_frame(input int w_reg, input int h_reg, input int mode);
        int ew, eh;
        write_reg(CFG_IDX_WIDTH, CFG_DATA_BITS'(w_reg));
        write_reg(CFG_IDX_HEIGHT, CFG_DATA_BITS'(h_reg));
        ew = (w_reg < 2) ? 2 : ((w_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w_reg);
        eh = (h_reg < 2) ? 2 : h_reg;
        for (int r = 0; r < eh; r++) begin
            for (int c = 0; c < ew; c++) begin
                if (mode == 2) directed_pixel(c, r);
                else send_pixel(16'($urandom), rand_depth(mode));
            end
        end
    endtask

    initial begin
        int w, h;
        quiet = 1'b0;
        idle_cycles = 0;
        random_pixels = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_IDX_WIDTH;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, saturation, no valid depth, odd column and row dropped
        run_frame(4, 4, 2);
        run_frame(3, 3, 0);
        run_frame(0, 1, 0);
        run_frame(1, 0, 0);

        // Wide and tall sparse-depth frames, no idling
        quiet = 1'b1;
        run_frame(40, 6, 1);
        run_frame(2, 40, 1);
        quiet = 1'b0;

        // Random frames of small sizes
        while (random_pixels < 950) begin
            w = $urandom_range(2, 24);
            h = $urandom_range(2, 10);
            quiet = ($urandom_range(0, 5) == 0);
            run_frame(w, h, 0);
            random_pixels += w * h;
        end
        quiet = 1'b0;

        // Drain
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS rgbd_frame_downsample_2x2_core");
        end else begin
            $display("FAIL rgbd_frame_downsample_2x2_core");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/rgbd_ds_pkg.sv
sv/rgbd_ds_ram.sv
sv/rgbd_ds_div.sv
sv/rgbd_ds_dp.sv
sv/rgbd_ds_ctrl.sv
sv/rgbd_frame_downsample_2x2_core.sv
tb/sv/rgbd_ds_checker.sv
tb/sv/tb.sv
